// ===== hw/rtl/bqc_pkg.sv =====
// Shared types and constants for the biquad cascade filter.
// Number formats, operation codes and the controller-to-datapath command word.
// No dependencies.
`timescale 1ns / 1ps

package bqc_pkg;

    // Default for the top-level MAX_SECTIONS parameter
    localparam int MAX_SECTIONS_DEF = 16;

    localparam int SMP_W     = 16;  // sample width
    localparam int SEC_IN_W  = 4;   // section field width
    localparam int CSEL_W    = 3;   // coef_select field width
    localparam int COEF_W    = 20;  // coefficient width, Q4.16
    localparam int COEF_FRAC = 16;
    localparam int SIG_W     = 40;  // internal signal width, Q24.16
    localparam int SIG_FRAC  = 16;
    localparam int HALF_W    = SIG_W / 2;
    localparam int PROD_W    = COEF_W + HALF_W + 1;
    localparam int ACC_W     = 62;
    localparam int CFG_W     = 5;
    localparam int NUM_COEFS = 5;
    localparam int STEP_W    = 4;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    // operation codes (s_tuser)
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    // coefficient selects, also the term order inside a section
    localparam logic [CSEL_W-1:0] CSEL_A1 = 3'd0;
    localparam logic [CSEL_W-1:0] CSEL_A2 = 3'd1;
    localparam logic [CSEL_W-1:0] CSEL_B0 = 3'd2;
    localparam logic [CSEL_W-1:0] CSEL_B1 = 3'd3;
    localparam logic [CSEL_W-1:0] CSEL_B2 = 3'd4;

    // multiplier signal operand
    typedef enum logic [1:0] {
        OPND_W1,
        OPND_W2,
        OPND_W0
    } bqc_opnd_t;

    typedef struct packed {
        logic              x_load;    // take sample, clear clip flag
        logic              coef_wr;   // coefficient write from input word
        logic              dly_rd;    // fetch w1/w2 of current section
        logic [CSEL_W-1:0] coef_term; // coefficient read address within section
        logic              mul_hi;    // multiply upper half of operand
        bqc_opnd_t         opnd;
        logic              acc_clr;   // preset accumulator to rounding half
        logic              acc_add;
        logic              w0_load;
        logic              y_load;    // section output becomes next input
        logic              dly_wr;
        logic              out_load;
    } bqc_cmd_t;

endpackage

// ===== hw/rtl/bqc_ctrl.sv =====
// Sequencer for the biquad cascade: handshakes, section loop, per-section schedule.
// Depends on bqc_pkg. Drives bqc_datapath through bqc_cmd_t.
`timescale 1ns / 1ps

module bqc_ctrl #(
    parameter int MAX_SECTIONS = bqc_pkg::MAX_SECTIONS_DEF,
    parameter int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_op,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic                      cfg_we,
    input  logic [bqc_pkg::CFG_W-1:0] cfg_wdata,
    output logic [SEC_W-1:0]          sec_idx,
    output bqc_pkg::bqc_cmd_t         cmd
);

    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

    // per-section schedule; a product lands in the step after its multiply
    localparam logic [bqc_pkg::STEP_W-1:0] STEP_READ   = 4'd0;
    localparam logic [bqc_pkg::STEP_W-1:0] STEP_A1_LO  = 4'd1;
    localparam logic [bqc_pkg::STEP_W-1:0] STEP_A1_HI  = 4'd2;
    localparam logic [bqc_pkg::STEP_W-1:0] STEP_A2_LO  = 4'd3;
    localparam logic [bqc_pkg::STEP_W-1:0] STEP_A2_HI  = 4'd4;
    localparam logic [bqc_pkg::STEP_W-1:0] STEP_FB_ACC = 4'd5;
    localparam logic [bqc_pkg::STEP_W-1:0] STEP_W0     = 4'd6;
    localparam logic [bqc_pkg::STEP_W-1:0] STEP_B0_LO  = 4'd7;
    localparam logic [bqc_pkg::STEP_W-1:0] STEP_B0_HI  = 4'd8;
    localparam logic [bqc_pkg::STEP_W-1:0] STEP_B1_LO  = 4'd9;
    localparam logic [bqc_pkg::STEP_W-1:0] STEP_B1_HI  = 4'd10;
    localparam logic [bqc_pkg::STEP_W-1:0] STEP_B2_LO  = 4'd11;
    localparam logic [bqc_pkg::STEP_W-1:0] STEP_B2_HI  = 4'd12;
    localparam logic [bqc_pkg::STEP_W-1:0] STEP_FF_ACC = 4'd13;
    localparam logic [bqc_pkg::STEP_W-1:0] STEP_Y      = 4'd14;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [bqc_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]            sec_cnt_reg, sec_cnt_next;
    logic [CNT_W-1:0]            nsec_reg, nsec_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic                        last_sec;
    logic                        out_free;

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign sec_idx  = sec_cnt_reg[SEC_W-1:0];
    assign last_sec = ((sec_cnt_reg + CNT_W'(1)) == nsec_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        if (!cfg_we) begin
            nsec_next = nsec_reg;
        end else if (32'(cfg_wdata) > MAX_SECTIONS) begin
            nsec_next = CNT_W'(MAX_SECTIONS);
        end else begin
            nsec_next = CNT_W'(cfg_wdata);
        end
    end

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        sec_cnt_next  = sec_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.opnd      = bqc_pkg::OPND_W1;
        cmd.coef_term = bqc_pkg::CSEL_B2;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (s_op == bqc_pkg::OP_COEF) begin
                        cmd.coef_wr = 1'b1;
                    end else begin
                        cmd.x_load   = 1'b1;
                        step_next    = STEP_READ;
                        sec_cnt_next = '0;
                        state_next   = (nsec_reg == '0) ? ST_FINISH : ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                step_next = step_reg + bqc_pkg::STEP_W'(1);
                unique case (step_reg)
                    STEP_READ: begin
                        cmd.dly_rd    = 1'b1;
                        cmd.acc_clr   = 1'b1;
                        cmd.coef_term = bqc_pkg::CSEL_A1;
                    end
                    STEP_A1_LO: begin
                        cmd.coef_term = bqc_pkg::CSEL_A1;
                        cmd.opnd      = bqc_pkg::OPND_W1;
                    end
                    STEP_A1_HI: begin
                        cmd.coef_term = bqc_pkg::CSEL_A2;
                        cmd.opnd      = bqc_pkg::OPND_W1;
                        cmd.mul_hi    = 1'b1;
                        cmd.acc_add   = 1'b1;
                    end
                    STEP_A2_LO: begin
                        cmd.coef_term = bqc_pkg::CSEL_A2;
                        cmd.opnd      = bqc_pkg::OPND_W2;
                        cmd.acc_add   = 1'b1;
                    end
                    STEP_A2_HI: begin
                        cmd.coef_term = bqc_pkg::CSEL_B0;
                        cmd.opnd      = bqc_pkg::OPND_W2;
                        cmd.mul_hi    = 1'b1;
                        cmd.acc_add   = 1'b1;
                    end
                    STEP_FB_ACC: begin
                        cmd.coef_term = bqc_pkg::CSEL_B0;
                        cmd.acc_add   = 1'b1;
                    end
                    STEP_W0: begin
                        cmd.coef_term = bqc_pkg::CSEL_B0;
                        cmd.w0_load   = 1'b1;
                        cmd.acc_clr   = 1'b1;
                    end
                    STEP_B0_LO: begin
                        cmd.coef_term = bqc_pkg::CSEL_B0;
                        cmd.opnd      = bqc_pkg::OPND_W0;
                    end
                    STEP_B0_HI: begin
                        cmd.coef_term = bqc_pkg::CSEL_B1;
                        cmd.opnd      = bqc_pkg::OPND_W0;
                        cmd.mul_hi    = 1'b1;
                        cmd.acc_add   = 1'b1;
                    end
                    STEP_B1_LO: begin
                        cmd.coef_term = bqc_pkg::CSEL_B1;
                        cmd.opnd      = bqc_pkg::OPND_W1;
                        cmd.acc_add   = 1'b1;
                    end
                    STEP_B1_HI: begin
                        cmd.coef_term = bqc_pkg::CSEL_B2;
                        cmd.opnd      = bqc_pkg::OPND_W1;
                        cmd.mul_hi    = 1'b1;
                        cmd.acc_add   = 1'b1;
                    end
                    STEP_B2_LO: begin
                        cmd.opnd    = bqc_pkg::OPND_W2;
                        cmd.acc_add = 1'b1;
                    end
                    STEP_B2_HI: begin
                        cmd.opnd    = bqc_pkg::OPND_W2;
                        cmd.mul_hi  = 1'b1;
                        cmd.acc_add = 1'b1;
                    end
                    STEP_FF_ACC: begin
                        cmd.acc_add = 1'b1;
                    end
                    STEP_Y: begin
                        cmd.y_load = 1'b1;
                        cmd.dly_wr = 1'b1;
                        step_next  = STEP_READ;
                        if (last_sec) begin
                            state_next = ST_FINISH;
                        end else begin
                            sec_cnt_next = sec_cnt_reg + CNT_W'(1);
                        end
                    end
                    default: begin
                        step_next = STEP_READ;
                    end
                endcase
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= STEP_READ;
            sec_cnt_reg  <= '0;
            nsec_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            sec_cnt_reg  <= sec_cnt_next;
            nsec_reg     <= nsec_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== hw/rtl/bqc_datapath.sv =====
// Datapath of the biquad cascade: coefficient and delay memories, shared
// 20x21 multiplier, accumulator, rounding and saturation. Depends on bqc_pkg.
`timescale 1ns / 1ps

module bqc_datapath #(
    parameter int MAX_SECTIONS = bqc_pkg::MAX_SECTIONS_DEF,
    parameter int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic signed [bqc_pkg::SMP_W-1:0]     s_sample,
    input  logic        [bqc_pkg::SEC_IN_W-1:0]  s_section,
    input  logic        [bqc_pkg::CSEL_W-1:0]    s_coef_select,
    input  logic signed [bqc_pkg::COEF_W-1:0]    s_coef_value,
    input  logic        [SEC_W-1:0]              sec_idx,
    input  bqc_pkg::bqc_cmd_t                    cmd,
    output logic signed [bqc_pkg::SMP_W-1:0]     m_filtered,
    output logic                                 m_saturated
);

    localparam int SIG_W  = bqc_pkg::SIG_W;
    localparam int HALF_W = bqc_pkg::HALF_W;
    localparam int ACC_W  = bqc_pkg::ACC_W;
    localparam int RND_W  = ACC_W - bqc_pkg::COEF_FRAC;
    localparam int DIFF_W = RND_W + 1;
    localparam int FIN_W  = SIG_W + 1;
    localparam int XR_W   = FIN_W - bqc_pkg::SIG_FRAC;
    localparam int SMP_W  = bqc_pkg::SMP_W;
    localparam int NCOEF  = MAX_SECTIONS * bqc_pkg::NUM_COEFS;
    localparam int CA_W   = $clog2(NCOEF);
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (bqc_pkg::COEF_FRAC - 1);
    localparam logic signed [FIN_W-1:0] FIN_HALF = FIN_W'(1) << (bqc_pkg::SIG_FRAC - 1);
    localparam logic [SIG_W-1:0] SIG_POS = {1'b0, {(SIG_W-1){1'b1}}};
    localparam logic [SIG_W-1:0] SIG_NEG = {1'b1, {(SIG_W-1){1'b0}}};
    localparam logic [SMP_W-1:0] SMP_POS = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic [SMP_W-1:0] SMP_NEG = {1'b1, {(SMP_W-1){1'b0}}};

    // memories; valid bits stand in for the zero reset
    logic [bqc_pkg::COEF_W-1:0] coef_mem [NCOEF];
    logic [NCOEF-1:0]           coef_vld_reg;
    logic [2*SIG_W-1:0]         dly_mem [MAX_SECTIONS];
    logic [MAX_SECTIONS-1:0]    dly_vld_reg;

    logic        [CA_W-1:0]              wr_addr, rd_addr;
    logic                                wr_ok;
    logic signed [bqc_pkg::COEF_W-1:0]   coef_rd_reg;
    logic signed [SIG_W-1:0]             w1_reg, w2_reg, w0_reg, x_reg;
    logic signed [SIG_W-1:0]             opnd_full;
    logic signed [HALF_W:0]              opnd_half;
    logic signed [bqc_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic                                prod_hi_reg;
    logic signed [ACC_W-1:0]             acc_reg, acc_next, prod_ext;
    logic signed [RND_W-1:0]             acc_rnd;
    logic signed [DIFF_W-1:0]            w0_diff;
    logic signed [SIG_W-1:0]             w0_sat, y_sat;
    logic                                w0_ovf, y_ovf;
    logic signed [FIN_W-1:0]             fin_sum;
    logic signed [XR_W-1:0]              fin_rnd;
    logic signed [SMP_W-1:0]             fin_sat;
    logic                                fin_ovf;
    logic                                sat_reg;
    logic signed [SMP_W-1:0]             filtered_reg;
    logic                                saturated_reg;

    assign wr_ok = cmd.coef_wr && (32'(s_section) < MAX_SECTIONS)
                   && (s_coef_select <= bqc_pkg::CSEL_B2);
    // sec * 5 + term
    assign wr_addr = (CA_W'(s_section) << 2) + CA_W'(s_section) + CA_W'(s_coef_select);
    assign rd_addr = (CA_W'(sec_idx) << 2) + CA_W'(sec_idx) + CA_W'(cmd.coef_term);

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            coef_mem[wr_addr] <= s_coef_value;
        end
        coef_rd_reg <= coef_vld_reg[rd_addr] ? coef_mem[rd_addr] : '0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.dly_wr) begin
            dly_mem[sec_idx] <= {w1_reg, w0_reg};
        end
        if (cmd.dly_rd) begin
            if (dly_vld_reg[sec_idx]) begin
                {w2_reg, w1_reg} <= dly_mem[sec_idx];
            end else begin
                w2_reg <= '0;
                w1_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_vld_reg <= '0;
            dly_vld_reg  <= '0;
        end else begin
            if (wr_ok) begin
                coef_vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.dly_wr) begin
                dly_vld_reg[sec_idx] <= 1'b1;
            end
        end
    end

    // 40-bit operand taken as signed upper half and unsigned lower half
    always_comb begin
        case (cmd.opnd)
            bqc_pkg::OPND_W1: opnd_full = w1_reg;
            bqc_pkg::OPND_W2: opnd_full = w2_reg;
            bqc_pkg::OPND_W0: opnd_full = w0_reg;
            default:          opnd_full = w1_reg;
        endcase
        if (cmd.mul_hi) begin
            opnd_half = {opnd_full[SIG_W-1], opnd_full[SIG_W-1:HALF_W]};
        end else begin
            opnd_half = {1'b0, opnd_full[HALF_W-1:0]};
        end
    end

    assign prod_next = coef_rd_reg * opnd_half;

    always_ff @(posedge aclk) begin
        prod_reg    <= prod_next;
        prod_hi_reg <= cmd.mul_hi;
    end

    always_comb begin
        prod_ext = ACC_W'(prod_reg);
        if (prod_hi_reg) begin
            prod_ext = prod_ext <<< HALF_W;
        end
        if (cmd.acc_clr) begin
            acc_next = ACC_HALF;
        end else if (cmd.acc_add) begin
            acc_next = acc_reg + prod_ext;
        end else begin
            acc_next = acc_reg;
        end
    end

    // accumulator starts at half an LSB, so a floor shift rounds
    assign acc_rnd = RND_W'(acc_reg >>> bqc_pkg::COEF_FRAC);
    assign w0_diff = DIFF_W'(x_reg) - DIFF_W'(acc_rnd);

    always_comb begin
        w0_ovf = !((&w0_diff[DIFF_W-1:SIG_W-1]) || !(|w0_diff[DIFF_W-1:SIG_W-1]));
        if (w0_ovf) begin
            w0_sat = w0_diff[DIFF_W-1] ? SIG_NEG : SIG_POS;
        end else begin
            w0_sat = w0_diff[SIG_W-1:0];
        end
        y_ovf = !((&acc_rnd[RND_W-1:SIG_W-1]) || !(|acc_rnd[RND_W-1:SIG_W-1]));
        if (y_ovf) begin
            y_sat = acc_rnd[RND_W-1] ? SIG_NEG : SIG_POS;
        end else begin
            y_sat = acc_rnd[SIG_W-1:0];
        end
    end

    assign fin_sum = FIN_W'(x_reg) + FIN_HALF;
    assign fin_rnd = fin_sum[FIN_W-1:bqc_pkg::SIG_FRAC];

    always_comb begin
        fin_ovf = !((&fin_rnd[XR_W-1:SMP_W-1]) || !(|fin_rnd[XR_W-1:SMP_W-1]));
        if (fin_ovf) begin
            fin_sat = fin_rnd[XR_W-1] ? SMP_NEG : SMP_POS;
        end else begin
            fin_sat = fin_rnd[SMP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (cmd.x_load) begin
            x_reg   <= {{(SIG_W-SMP_W-bqc_pkg::SIG_FRAC){s_sample[SMP_W-1]}}, s_sample,
                        {bqc_pkg::SIG_FRAC{1'b0}}};
            sat_reg <= 1'b0;
        end else if (cmd.w0_load) begin
            sat_reg <= sat_reg | w0_ovf;
        end else if (cmd.y_load) begin
            x_reg   <= y_sat;
            sat_reg <= sat_reg | y_ovf;
        end
        if (cmd.w0_load) begin
            w0_reg <= w0_sat;
        end
        if (cmd.out_load) begin
            filtered_reg  <= fin_sat;
            saturated_reg <= sat_reg | fin_ovf;
        end
    end

    assign m_filtered  = filtered_reg;
    assign m_saturated = saturated_reg;

endmodule

// ===== hw/rtl/biquad_cascade_filter.sv =====
// Top level of the biquad cascade filter (direct form II, fixed point).
// Depends on bqc_pkg, bqc_ctrl and bqc_datapath.
//
//  channel  | ports                      | word
//  ---------+----------------------------+---------------------------------------
//  input    | s_tvalid s_tready s_tdata  | filter sample or coefficient write
//           | s_tuser                    |
//  result   | m_tvalid m_tready m_tdata  | filtered sample plus clip flag
//           | m_tuser                    |
//  config   | cfg_we cfg_wdata           | section_count
//
// A coefficient write is taken without leaving the idle state. A sample runs
// through the N active sections in turn: each section runs 10 passes through one shared 20x21
// multiplier plus memory read, rounding and write-back steps.
// Reset (aresetn low, synchronous) zeroes section_count, coefficients and delays.
// The result sits in an output register; the next word is taken while it waits,
// and a finished sample stalls only until that register frees up.
`timescale 1ns / 1ps

module biquad_cascade_filter #(
    parameter int MAX_SECTIONS = bqc_pkg::MAX_SECTIONS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sample[15:0], section[19:16], coef_select[22:20], coef_value[42:23], zero pad
    input  logic [bqc_pkg::IN_DATA_W-1:0]  s_tdata,
    // operation
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // filtered[15:0]
    output logic [bqc_pkg::OUT_DATA_W-1:0] m_tdata,
    // saturated
    output logic                           m_tuser,
    input  logic                           cfg_we,
    input  logic [bqc_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    logic signed [bqc_pkg::SMP_W-1:0]    s_sample;
    logic        [bqc_pkg::SEC_IN_W-1:0] s_section;
    logic        [bqc_pkg::CSEL_W-1:0]   s_coef_select;
    logic signed [bqc_pkg::COEF_W-1:0]   s_coef_value;
    logic signed [bqc_pkg::SMP_W-1:0]    m_filtered;
    logic        [SEC_W-1:0]             sec_idx;
    bqc_pkg::bqc_cmd_t                   cmd;

    assign s_sample      = s_tdata[15:0];
    assign s_section     = s_tdata[19:16];
    assign s_coef_select = s_tdata[22:20];
    assign s_coef_value  = s_tdata[42:23];
    assign m_tdata       = m_filtered;

    bqc_ctrl #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .SEC_W        (SEC_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_op      (s_tuser),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sec_idx   (sec_idx),
        .cmd       (cmd)
    );

    bqc_datapath #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .SEC_W        (SEC_W)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_sample      (s_sample),
        .s_section     (s_section),
        .s_coef_select (s_coef_select),
        .s_coef_value  (s_coef_value),
        .sec_idx       (sec_idx),
        .cmd           (cmd),
        .m_filtered    (m_filtered),
        .m_saturated   (m_tuser)
    );

endmodule

// ===== tb/bqc_checker.sv =====
// Checker for the biquad cascade filter: watches the config port and both streams,
// predicts each filtered word and compares it with what the block delivers.
// Depends on bqc_pkg.
`timescale 1ns / 1ps

module bqc_checker #(
    parameter int MAX_SECTIONS = bqc_pkg::MAX_SECTIONS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [bqc_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [bqc_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           m_tuser,
    input  logic                           cfg_we,
    input  logic [bqc_pkg::CFG_W-1:0]      cfg_wdata,
    output int                             fail_count,
    output int                             pending
);
    import bqc_pkg::*;

    localparam int SEC_LSB  = SMP_W;
    localparam int CSEL_LSB = SEC_LSB + SEC_IN_W;
    localparam int CVAL_LSB = CSEL_LSB + CSEL_W;

    typedef struct packed {
        logic [SMP_W-1:0] filtered;
        logic             saturated;
    } filter_out_t;

    filter_out_t              filtered_q[$];
    filter_out_t              got_word;
    filter_out_t              want_word;
    logic [CFG_W-1:0]         section_cfg;
    logic signed [SIG_W-1:0]  w1_mem [MAX_SECTIONS];
    logic signed [SIG_W-1:0]  w2_mem [MAX_SECTIONS];
    logic signed [COEF_W-1:0] coef_mem [MAX_SECTIONS*NUM_COEFS];
    logic [SEC_IN_W-1:0]      wr_sec;
    logic [CSEL_W-1:0]        wr_sel;
    logic                     clip_seen;
    int                       fails = 0;

    function automatic longint round_shift(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    // saturate to a signed width, remember that clipping happened
    function automatic longint clamp_to(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            clip_seen = 1'b1;
            return hi;
        end
        if (v < lo) begin
            clip_seen = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic longint coef_at(input int sec, input logic [CSEL_W-1:0] sel);
        return longint'(coef_mem[sec*NUM_COEFS + int'(sel)]);
    endfunction

    // runs one sample through the active sections, updating the delay lines
    function automatic filter_out_t filter_sample(input logic signed [SMP_W-1:0] smp);
        int          n;
        int          s;
        longint      x;
        longint      y;
        longint      w0;
        longint      w1;
        longint      w2;
        longint      acc;
        filter_out_t res;
        n = (section_cfg > MAX_SECTIONS) ? MAX_SECTIONS : int'(section_cfg);
        clip_seen = 1'b0;
        x = longint'(smp) <<< SIG_FRAC;
        for (s = 0; s < n; s++) begin
            w1  = longint'(w1_mem[s]);
            w2  = longint'(w2_mem[s]);
            acc = coef_at(s, CSEL_A1) * w1 + coef_at(s, CSEL_A2) * w2;
            w0  = clamp_to(x - round_shift(acc, COEF_FRAC), SIG_W);
            acc = coef_at(s, CSEL_B0) * w0 + coef_at(s, CSEL_B1) * w1
                + coef_at(s, CSEL_B2) * w2;
            y   = clamp_to(round_shift(acc, COEF_FRAC), SIG_W);
            w2_mem[s] = w1_mem[s];
            w1_mem[s] = w0[SIG_W-1:0];
            x = y;
        end
        y = clamp_to(round_shift(x, SIG_FRAC), SMP_W);
        res.filtered  = y[SMP_W-1:0];
        res.saturated = clip_seen;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            section_cfg = '0;
            foreach (w1_mem[i]) w1_mem[i] = '0;
            foreach (w2_mem[i]) w2_mem[i] = '0;
            foreach (coef_mem[i]) coef_mem[i] = '0;
            filtered_q.delete();
        end else begin
            if (cfg_we)
                section_cfg = cfg_wdata;
            // results leave before the new word is taken: no result leaves in the cycle its word is taken
            if (m_tvalid && m_tready) begin
                got_word.filtered  = m_tdata;
                got_word.saturated = m_tuser;
                if (filtered_q.size() == 0) begin
                    $error("filtered: expected nothing, got %0d", $signed(m_tdata));
                    fails++;
                end else begin
                    want_word = filtered_q.pop_front();
                    if (got_word.filtered !== want_word.filtered) begin
                        $error("filtered: expected %0d, got %0d",
                               $signed(want_word.filtered), $signed(got_word.filtered));
                        fails++;
                    end
                    if (got_word.saturated !== want_word.saturated) begin
                        $error("saturated: expected %0d, got %0d",
                               want_word.saturated, got_word.saturated);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_COEF) begin
                    wr_sec = s_tdata[SEC_LSB +: SEC_IN_W];
                    wr_sel = s_tdata[CSEL_LSB +: CSEL_W];
                    if (wr_sel <= CSEL_B2 && int'(wr_sec) < MAX_SECTIONS)
                        coef_mem[int'(wr_sec)*NUM_COEFS + int'(wr_sel)] =
                            s_tdata[CVAL_LSB +: COEF_W];
                end else begin
                    filtered_q.push_back(filter_sample(s_tdata[SMP_W-1:0]));
                end
            end
        end
        fail_count <= fails;
        pending    <= filtered_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the biquad cascade filter testbench: clock, reset, stimulus, result sink,
// watchdog and verdict. Depends on bqc_pkg, biquad_cascade_filter and bqc_checker.
`timescale 1ns / 1ps

module tb_top;
    import bqc_pkg::*;

    localparam int MAX_SEC           = MAX_SECTIONS_DEF;
    localparam int HOLD_CYCLES       = 600;
    // longest quiet stretch: receiver hold plus a full 16-section sample plus gaps
    localparam int IDLE_LIMIT        = 5000;
    localparam int SAMPLES_PER_PHASE = 125;
    localparam int SETTLE_CYCLES     = 20;
    localparam int TAIL_CYCLES       = 300;
    localparam int PAD_W             = IN_DATA_W - SMP_W - SEC_IN_W - CSEL_W - COEF_W;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = OP_FILTER;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    int fail_count;
    int pending;
    bit burst;
    int holds_asked;
    int holds_served;
    int idle_cycles;

    biquad_cascade_filter #(.MAX_SECTIONS(MAX_SEC)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    bqc_checker #(.MAX_SECTIONS(MAX_SEC)) chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // valid stays high across back-to-back words; this task only drops it when a gap is drawn
    task automatic send_word(input logic op, input logic [SMP_W-1:0] smp,
                             input logic [SEC_IN_W-1:0] sec, input logic [CSEL_W-1:0] sel,
                             input logic [COEF_W-1:0] val);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{PAD_W{1'b0}}, val, sel, sec, smp};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_sample(input logic [SMP_W-1:0] smp);
        send_word(OP_FILTER, smp, SEC_IN_W'($urandom), CSEL_W'($urandom), COEF_W'($urandom));
    endtask

    // stop offering, wait for every outstanding result, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_sections(input logic [CFG_W-1:0] n);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [COEF_W-1:0] pick_coef(input logic [CSEL_W-1:0] sel);
        int v;
        if ($urandom_range(0, 7) == 0)
            return COEF_W'($urandom);
        case (sel)
            CSEL_A1: v = int'($urandom_range(0, 240000)) - 120000;
            CSEL_A2: v = int'($urandom_range(0, 120000)) - 60000;
            default: v = int'($urandom_range(0, 131072)) - 65536;
        endcase
        return v[COEF_W-1:0];
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 3))
            0: return SMP_W'($urandom);
            1: v = int'($urandom_range(0, 1024)) - 512;
            2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: v = int'($urandom_range(0, 16384)) - 8192;
        endcase
        return v[SMP_W-1:0];
    endfunction

    // full coefficient set for the first n sections
    task automatic load_sections(input int n);
        logic [CSEL_W-1:0] sel;
        for (int s = 0; s < n; s++) begin
            for (int k = 0; k < NUM_COEFS; k++) begin
                sel = CSEL_W'(k);
                send_word(OP_COEF, SMP_W'($urandom), SEC_IN_W'(s), sel, pick_coef(sel));
            end
        end
    endtask

    // result sink
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            if (holds_asked > holds_served) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = burst ? 0 : $urandom_range(0, 13);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int phase_counts[12] = '{1, 2, 3, 16, 0, 31, 5, 2, 8, 1, 4, 17};
        int n;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: pass-through at reset count, extremes, ignored selects
        send_word(OP_FILTER, 16'h7FFF, 4'hF, 3'h7, 20'hFFFFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_word(OP_COEF, 16'hFFFF, 4'd0, CSEL_B0, 20'h7FFFF);
        send_word(OP_COEF, 16'h0000, 4'd0, CSEL_A1, 20'h80000);
        send_word(OP_COEF, 16'h1234, 4'd15, 3'd5, 20'h00001);
        send_word(OP_COEF, 16'h0000, 4'd15, 3'd7, 20'hFFFFF);
        send_word(OP_COEF, 16'h0000, 4'd15, CSEL_B0, 20'h10000);
        set_sections(CFG_W'(1));
        // a1 = -8 makes w0 run away into the 40-bit clip
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h7FFF);
        // count above the section limit clamps to all sections
        set_sections(CFG_W'(31));
        send_sample(16'h7FFF);
        send_sample(16'h8000);

        foreach (phase_counts[p]) begin
            burst = (p % 4 == 2);
            set_sections(CFG_W'(phase_counts[p]));
            n = (phase_counts[p] > MAX_SEC) ? MAX_SEC : phase_counts[p];
            load_sections(n);
            for (int i = 0; i < SAMPLES_PER_PHASE; i++) begin
                if (p == 1 && i == 30)
                    holds_asked++;
                if (p == 6 && i == 60)
                    drain();
                if ($urandom_range(0, 19) == 0)
                    send_word(OP_COEF, SMP_W'($urandom), SEC_IN_W'($urandom),
                              CSEL_W'($urandom), pick_coef(CSEL_W'($urandom)));
                else
                    send_sample(pick_sample());
            end
        end

        burst = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
